// ----- src/flvtd_pkg.sv -----
// ----------------------------------------------------------------------------
// flvtd_pkg
// Types and constants used by the FLV tag deframer; the channel interfaces
// do not import them.
// ----------------------------------------------------------------------------
`default_nettype none

package flvtd_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_FILEHDR = 3'd0,
		PH_SKIP    = 3'd1,
		PH_PTS0    = 3'd2,
		PH_TAGHDR  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_TRAILER = 3'd5,
		PH_HALT    = 3'd6
	} phase_t;

	// latched error codes
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_SIG      = 2'd1,
		ERR_OFFSET   = 2'd2,
		ERR_TRAILER  = 2'd3
	} err_t;

	// signature bytes
	localparam logic [7:0] SIG_F = 8'h46;
	localparam logic [7:0] SIG_L = 8'h4C;
	localparam logic [7:0] SIG_V = 8'h56;

	// field lengths in bytes, and the index of the first data offset byte
	localparam logic [31:0] FILE_HDR_LEN = 32'd9;
	localparam logic [31:0] TAG_HDR_LEN  = 32'd11;
	localparam logic [31:0] PTS_LEN      = 32'd4;
	localparam logic [31:0] TRAILER_LEN  = 32'd4;
	localparam logic [31:0] OFFSET_FIRST = 32'd5;

	localparam logic [7:0] TYPE_MASK = 8'h1F;

endpackage

`default_nettype wire

// ----- src/flvtd_in_if.sv -----
// ----------------------------------------------------------------------------
// flvtd_in_if
// Byte channel into the deframer: one file byte and a restart flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface flvtd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       restart;

	modport source (output valid, output file_byte, output restart, input ready);
	modport sink   (input valid, input file_byte, input restart, output ready);
endinterface

`default_nettype wire

// ----- src/flvtd_out_if.sv -----
// ----------------------------------------------------------------------------
// flvtd_out_if
// Result channel out of the deframer: one result beat per input byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface flvtd_out_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [4:0]  tag_type;
	logic [23:0] tag_size;
	logic [31:0] tag_timestamp;
	logic        payload_last;
	logic        tag_end;
	logic [1:0]  error_code;

	modport source (
		output valid, output payload_valid, output payload_byte, output tag_type,
		output tag_size, output tag_timestamp, output payload_last, output tag_end,
		output error_code, input ready
	);
	modport sink (
		input valid, input payload_valid, input payload_byte, input tag_type,
		input tag_size, input tag_timestamp, input payload_last, input tag_end,
		input error_code, output ready
	);
endinterface

`default_nettype wire

// ----- src/flv_tag_deframer.sv -----
// Output: the result register captures a result beat at the edge that accepts
//   its byte beat.
// Throughput: one byte per cycle while the result register is empty or result.ready is high; the parser state
//   and the result register both update at the accepting edge, so bytes can stream back to back.
// Reset: arst_n clears the parser to the file header phase with no error and
//   empties the result register; a restart beat clears the parser state in-band and is parsed as the first header byte.
// ----------------------------------------------------------------------------
// flv_tag_deframer
// Byte-serial FLV tag parser: checks the file header, skips to the first tag,
// unpacks tag headers, forwards payload and checks each tag's trailing size.
// ----------------------------------------------------------------------------
`default_nettype none

module flv_tag_deframer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	flvtd_in_if.sink   stream,
	flvtd_out_if.source result
);
	import flvtd_pkg::*;

	// parser state
	phase_t      phase_q, phase_n;
	logic [31:0] cnt_q, cnt_n;
	logic [31:0] hoff_q, hoff_n;
	logic [4:0]  type_q, type_n;
	logic [23:0] size_q, size_n;
	logic [31:0] ts_q, ts_n;
	logic [31:0] trl_q, trl_n;
	err_t        err_q, err_n;

	// state as seen by this byte, after an optional restart
	phase_t      ph_c;
	logic [31:0] cnt_c, hoff_c, trl_c, ts_c, cnt_inc;
	logic [4:0]  type_c;
	logic [23:0] size_c;
	logic [31:0] size_p11;
	logic        sig_bad;

	// per-beat result flags
	logic pv, plast, tend;

	// result register
	logic        out_valid_q;
	logic        pv_q, plast_q, tend_q;
	logic [7:0]  byte_q;
	logic [4:0]  rtype_q;
	logic [23:0] rsize_q;
	logic [31:0] rts_q;
	err_t        rerr_q;

	logic accept;
	logic [7:0] b;

	assign b      = stream.file_byte;
	assign stream.ready = !out_valid_q || result.ready;
	assign accept = stream.valid && stream.ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FILEHDR;
			cnt_q   <= '0;
			hoff_q  <= '0;
			type_q  <= '0;
			size_q  <= '0;
			ts_q    <= '0;
			trl_q   <= '0;
			err_q   <= ERR_NONE;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			hoff_q  <= hoff_n;
			type_q  <= type_n;
			size_q  <= size_n;
			ts_q    <= ts_n;
			trl_q   <= trl_n;
			err_q   <= err_n;
		end
	end

	// next state and result for one byte
	always_comb begin
		ph_c   = stream.restart ? PH_FILEHDR : phase_q;
		cnt_c  = stream.restart ? '0 : cnt_q;
		hoff_c = stream.restart ? '0 : hoff_q;
		type_c = stream.restart ? '0 : type_q;
		size_c = stream.restart ? '0 : size_q;
		ts_c   = stream.restart ? '0 : ts_q;
		trl_c  = stream.restart ? '0 : trl_q;
		cnt_inc  = cnt_c + 32'd1;
		size_p11 = {8'd0, size_c} + TAG_HDR_LEN;
		sig_bad  = (cnt_c == 32'd0 && b != SIG_F) || (cnt_c == 32'd1 && b != SIG_L)
			|| (cnt_c == 32'd2 && b != SIG_V);

		phase_n = ph_c;
		cnt_n   = cnt_c;
		hoff_n  = hoff_c;
		type_n  = type_c;
		size_n  = size_c;
		ts_n    = ts_c;
		trl_n   = trl_c;
		err_n   = stream.restart ? ERR_NONE : err_q;
		pv      = 1'b0;
		plast   = 1'b0;
		tend    = 1'b0;

		unique case (ph_c)
			PH_FILEHDR: begin
				if (sig_bad) begin
					err_n   = ERR_SIG;
					phase_n = PH_HALT;
				end else begin
					if (cnt_c >= OFFSET_FIRST) hoff_n = {hoff_c[23:0], b};
					cnt_n = cnt_inc;
					if (cnt_inc == FILE_HDR_LEN) begin
						cnt_n = '0;
						if (hoff_n < FILE_HDR_LEN) begin
							err_n   = ERR_OFFSET;
							phase_n = PH_HALT;
						end else if (hoff_n > FILE_HDR_LEN) begin
							phase_n = PH_SKIP;
						end else begin
							phase_n = PH_PTS0;
						end
					end
				end
			end
			PH_SKIP: begin
				cnt_n = cnt_inc;
				if (cnt_inc == hoff_c - FILE_HDR_LEN) begin
					cnt_n   = '0;
					phase_n = PH_PTS0;
				end
			end
			PH_PTS0: begin
				cnt_n = cnt_inc;
				if (cnt_inc == PTS_LEN) begin
					cnt_n   = '0;
					phase_n = PH_TAGHDR;
				end
			end
			PH_TAGHDR: begin
				unique case (cnt_c)
					32'd0: begin
						type_n = b[4:0] & TYPE_MASK[4:0];
						size_n = '0;
						ts_n   = '0;
					end
					32'd1, 32'd2, 32'd3: size_n = {size_c[15:0], b};
					32'd4: ts_n[23:16] = b;
					32'd5: ts_n[15:8]  = b;
					32'd6: ts_n[7:0]   = b;
					32'd7: ts_n[31:24] = b;
					default: ;
				endcase
				cnt_n = cnt_inc;
				if (cnt_inc == TAG_HDR_LEN) begin
					cnt_n   = '0;
					trl_n   = '0;
					phase_n = (size_n == 24'd0) ? PH_TRAILER : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				pv    = 1'b1;
				cnt_n = cnt_inc;
				if (cnt_inc >= {8'd0, size_c}) begin
					plast   = 1'b1;
					cnt_n   = '0;
					trl_n   = '0;
					phase_n = PH_TRAILER;
				end
			end
			PH_TRAILER: begin
				trl_n = {trl_c[23:0], b};
				cnt_n = cnt_inc;
				if (cnt_inc == TRAILER_LEN) begin
					cnt_n = '0;
					if (trl_n == size_p11) begin
						tend    = 1'b1;
						phase_n = PH_TAGHDR;
					end else begin
						err_n   = ERR_TRAILER;
						phase_n = PH_HALT;
					end
				end
			end
			default: ;
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pv_q    <= pv;
			plast_q <= plast;
			tend_q  <= tend;
			byte_q  <= pv ? b : 8'd0;
			rtype_q <= pv ? type_c : 5'd0;
			rsize_q <= pv ? size_c : 24'd0;
			rts_q   <= pv ? ts_c : 32'd0;
			rerr_q  <= err_n;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.payload_valid = pv_q;
	assign result.payload_byte  = byte_q;
	assign result.tag_type      = rtype_q;
	assign result.tag_size      = rsize_q;
	assign result.tag_timestamp = rts_q;
	assign result.payload_last  = plast_q;
	assign result.tag_end       = tend_q;
	assign result.error_code    = rerr_q;

`ifndef SYNTHESIS
	// an error is latched exactly while the parser is halted
	a_err_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) == (phase_q == PH_HALT))
		else $error("error latch and halt phase disagree");

	// only a restart beat leaves the halt phase
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT && !(accept && stream.restart)) |=> (phase_q == PH_HALT))
		else $error("halt phase left without restart");

	// last flag only on a payload beat
	a_last_pv: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && plast_q) |-> pv_q)
		else $error("payload_last without payload_valid");

	// a completed tag never carries an error
	a_end_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tend_q) |-> (rerr_q == ERR_NONE && !pv_q))
		else $error("tag_end with error or payload");
`endif

endmodule

`default_nettype wire
